### hw/rtl/tpe_pkg.sv
// ----------------------------------------------------------------------------
// tpe_pkg
// shared types and constants of the triangle plane equation unit
// ----------------------------------------------------------------------------
package tpe_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_FACE   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      SEL_A = 2'd0,
      SEL_B = 2'd1,
      SEL_C = 2'd2
   } corner_sel_type;

   typedef enum logic [3:0] {
      MUL_NONE  = 4'd0,
      MUL_X0    = 4'd1,
      MUL_X1    = 4'd2,
      MUL_Y0    = 4'd3,
      MUL_Y1    = 4'd4,
      MUL_Z0    = 4'd5,
      MUL_Z1    = 4'd6,
      MUL_SQ_A  = 4'd7,
      MUL_SQ_B  = 4'd8,
      MUL_SQ_C  = 4'd9,
      MUL_DOT_A = 4'd10,
      MUL_DOT_B = 4'd11,
      MUL_DOT_C = 4'd12
   } mul_op_type;

   // floor(0.1 * 2^64)
   localparam logic [63:0] TENTH_Q64 = 64'h1999_9999_9999_9999;

   localparam int STEP_W     = 5;
   localparam int CROSS_OPS  = 6;
   localparam int SQ_OPS     = 3;
   localparam int DOT_OPS    = 3;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;

   typedef struct packed {
      logic           wr_en;
      logic           cap_face;
      logic           rd_en;
      corner_sel_type rd_sel;
      logic           cap_p0;
      logic           cap_p1;
      logic           cap_p2;
      logic           edge_en;
      mul_op_type     mul_op;
      logic           abs_en;
      logic           norm_step;
      logic           sum_init;
      logic           sqrt_init;
      logic           sqrt_step;
      logic           div_init;
      logic           div_step;
      logic           load_out;
      logic           oob;
   } dp_cmd_type;

   typedef struct packed {
      logic norm_done;
   } dp_status_type;

endpackage

### hw/rtl/tpe_ctrl.sv
// ----------------------------------------------------------------------------
// tpe_ctrl
// sequencer: handshake, vertex count, range check and face step schedule
// ----------------------------------------------------------------------------
module tpe_ctrl import tpe_pkg::*; #(
   parameter int VERTEX_DEPTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [11:0]                       req_corner_a,
   input  logic [11:0]                       req_corner_b,
   input  logic [11:0]                       req_corner_c,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dp_cmd_type                        cmd,
   output logic [$clog2(VERTEX_DEPTH)-1:0]   wr_addr,
   input  dp_status_type                     sts
);

   localparam int AW   = $clog2(VERTEX_DEPTH);
   localparam int CW   = $clog2(VERTEX_DEPTH + 1);
   localparam int CMPW = (CW > 12) ? CW : 12;
   localparam int WAW  = (AW > CW) ? AW : CW;

   typedef enum logic [17:0] {
      ST_IDLE      = 18'h00001,
      ST_RD_A      = 18'h00002,
      ST_RD_B      = 18'h00004,
      ST_RD_C      = 18'h00008,
      ST_CAP_C     = 18'h00010,
      ST_EDGE      = 18'h00020,
      ST_CROSS     = 18'h00040,
      ST_CROSS_END = 18'h00080,
      ST_ABS       = 18'h00100,
      ST_NORM      = 18'h00200,
      ST_SQ        = 18'h00400,
      ST_SQ_END    = 18'h00800,
      ST_SQRT      = 18'h01000,
      ST_DIV_INIT  = 18'h02000,
      ST_DIV       = 18'h04000,
      ST_DOT       = 18'h08000,
      ST_DOT_END   = 18'h10000,
      ST_FIN       = 18'h20000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              oob_ff, oob_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              oob;
   logic [CMPW-1:0]   count_cmp;
   logic [WAW-1:0]    count_wide;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign accept     = req_valid && req_ready;
   assign count_cmp  = CMPW'(count_ff);
   assign count_wide = WAW'(count_ff);
   assign wr_addr    = count_wide[AW-1:0];
   assign oob        = (CMPW'(req_corner_a) >= count_cmp) ||
                       (CMPW'(req_corner_b) >= count_cmp) ||
                       (CMPW'(req_corner_c) >= count_cmp);

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = SEL_A;
      cmd.mul_op   = MUL_NONE;
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      oob_in       = oob_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_CLEAR) begin
                  count_in = '0;
               end else if (req_action == ACT_APPEND) begin
                  if (count_ff != CW'(VERTEX_DEPTH)) begin
                     cmd.wr_en = 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
               end else if (req_action == ACT_FACE) begin
                  cmd.cap_face = 1'b1;
                  oob_in       = oob;
                  state_in     = oob ? ST_FIN : ST_RD_A;
               end
            end
         end
         ST_RD_A: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_A;
            state_in   = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_B;
            cmd.cap_p0 = 1'b1;
            state_in   = ST_RD_C;
         end
         ST_RD_C: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_C;
            cmd.cap_p1 = 1'b1;
            state_in   = ST_CAP_C;
         end
         ST_CAP_C: begin
            cmd.cap_p2 = 1'b1;
            state_in   = ST_EDGE;
         end
         ST_EDGE: begin
            cmd.edge_en = 1'b1;
            step_in     = '0;
            state_in    = ST_CROSS;
         end
         ST_CROSS: begin
            unique case (step_ff)
               STEP_W'(0): cmd.mul_op = MUL_X0;
               STEP_W'(1): cmd.mul_op = MUL_X1;
               STEP_W'(2): cmd.mul_op = MUL_Y0;
               STEP_W'(3): cmd.mul_op = MUL_Y1;
               STEP_W'(4): cmd.mul_op = MUL_Z0;
               default:    cmd.mul_op = MUL_Z1;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CROSS_OPS - 1)) begin
               step_in  = '0;
               state_in = ST_CROSS_END;
            end
         end
         ST_CROSS_END: state_in = ST_ABS;
         ST_ABS: begin
            cmd.abs_en = 1'b1;
            state_in   = ST_NORM;
         end
         ST_NORM: begin
            if (sts.norm_done) begin
               state_in = ST_SQ;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_SQ: begin
            unique case (step_ff)
               STEP_W'(0): begin
                  cmd.mul_op   = MUL_SQ_A;
                  cmd.sum_init = 1'b1;
               end
               STEP_W'(1): cmd.mul_op = MUL_SQ_B;
               default:    cmd.mul_op = MUL_SQ_C;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQ_OPS - 1)) begin
               step_in  = '0;
               state_in = ST_SQ_END;
            end
         end
         ST_SQ_END: begin
            cmd.sqrt_init = 1'b1;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            unique case (step_ff)
               STEP_W'(0): cmd.mul_op = MUL_DOT_A;
               STEP_W'(1): cmd.mul_op = MUL_DOT_B;
               default:    cmd.mul_op = MUL_DOT_C;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DOT_OPS - 1)) begin
               step_in  = '0;
               state_in = ST_DOT_END;
            end
         end
         ST_DOT_END: state_in = ST_FIN;
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               cmd.oob      = oob_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         oob_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         oob_ff       <= oob_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/tpe_datapath.sv
// ----------------------------------------------------------------------------
// tpe_datapath
// vertex memory, shared multiplier, normalizer, square root, dividers, output
// ----------------------------------------------------------------------------
module tpe_datapath import tpe_pkg::*; #(
   parameter int VERTEX_DEPTH = 4096
) (
   input  logic                              clock,
   input  dp_cmd_type                        cmd,
   input  logic [$clog2(VERTEX_DEPTH)-1:0]   wr_addr,
   input  logic signed [31:0]                req_pos_x,
   input  logic signed [31:0]                req_pos_y,
   input  logic signed [31:0]                req_pos_z,
   input  logic [11:0]                       req_corner_a,
   input  logic [11:0]                       req_corner_b,
   input  logic [11:0]                       req_corner_c,
   output dp_status_type                     sts,
   output logic                              rsp_status,
   output logic signed [31:0]                rsp_normal_a,
   output logic signed [31:0]                rsp_normal_b,
   output logic signed [31:0]                rsp_normal_c,
   output logic signed [47:0]                rsp_plane_offset
);

   localparam int AW = $clog2(VERTEX_DEPTH);
   localparam int IW = (AW > 12) ? AW : 12;

   logic [95:0]        mem [VERTEX_DEPTH];
   logic [95:0]        rd_q_ff;
   logic [11:0]        ca_ff, cb_ff, cc_ff;
   logic [11:0]        sel_idx;
   logic [IW-1:0]      idx_ext;
   logic [AW-1:0]      rd_addr;

   logic signed [31:0] rd_pt [3];
   logic signed [31:0] p0_ff [3];
   logic signed [31:0] p1_ff [3];
   logic signed [31:0] p2_ff [3];
   logic signed [32:0] e1_ff [3];
   logic signed [32:0] e2_ff [3];

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff;
   mul_op_type         pend_ff;

   logic signed [66:0] n_ff [3];
   logic [65:0]        m_ff [3];
   logic               neg_ff [3];
   logic [65:0]        m_or;
   logic [5:0]         s_ff;
   logic [6:0]         k_sh;
   logic [63:0]        k_val;
   logic [63:0]        sum_ff;

   logic [34:0]        rem_ff;
   logic [31:0]        root_ff;
   logic [34:0]        rem_sh;
   logic [34:0]        trial;
   logic [31:0]        divisor;

   logic [61:0]        den_ff;
   logic [60:0]        dr_ff [3];
   logic [30:0]        q_ff [3];
   logic signed [31:0] coef [3];

   logic signed [65:0] dot_ff;
   logic [65:0]        dot_mag;
   logic [49:0]        dm;
   logic [49:0]        d_val;

   // vertex memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= {req_pos_z, req_pos_y, req_pos_x};
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         SEL_A:   sel_idx = ca_ff;
         SEL_B:   sel_idx = cb_ff;
         SEL_C:   sel_idx = cc_ff;
         default: sel_idx = ca_ff;
      endcase
   end

   assign idx_ext = IW'(sel_idx);
   assign rd_addr = idx_ext[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign rd_pt[0] = rd_q_ff[31:0];
   assign rd_pt[1] = rd_q_ff[63:32];
   assign rd_pt[2] = rd_q_ff[95:64];

   always_ff @(posedge clock) begin
      if (cmd.cap_face) begin
         ca_ff <= req_corner_a;
         cb_ff <= req_corner_b;
         cc_ff <= req_corner_c;
      end
      for (int k = 0; k < 3; k++) begin
         if (cmd.cap_p0) p0_ff[k] <= rd_pt[k];
         if (cmd.cap_p1) p1_ff[k] <= rd_pt[k];
         if (cmd.cap_p2) p2_ff[k] <= rd_pt[k];
         if (cmd.edge_en) begin
            e1_ff[k] <= 33'(p1_ff[k]) - 33'(p0_ff[k]);
            e2_ff[k] <= 33'(p2_ff[k]) - 33'(p0_ff[k]);
         end
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_op)
         MUL_X0:    begin mul_a = 34'(e1_ff[1]); mul_b = 34'(e2_ff[2]); end
         MUL_X1:    begin mul_a = 34'(e1_ff[2]); mul_b = 34'(e2_ff[1]); end
         MUL_Y0:    begin mul_a = 34'(e1_ff[2]); mul_b = 34'(e2_ff[0]); end
         MUL_Y1:    begin mul_a = 34'(e1_ff[0]); mul_b = 34'(e2_ff[2]); end
         MUL_Z0:    begin mul_a = 34'(e1_ff[0]); mul_b = 34'(e2_ff[1]); end
         MUL_Z1:    begin mul_a = 34'(e1_ff[1]); mul_b = 34'(e2_ff[0]); end
         MUL_SQ_A:  begin
            mul_a = $signed({3'b000, m_ff[0][30:0]});
            mul_b = $signed({3'b000, m_ff[0][30:0]});
         end
         MUL_SQ_B:  begin
            mul_a = $signed({3'b000, m_ff[1][30:0]});
            mul_b = $signed({3'b000, m_ff[1][30:0]});
         end
         MUL_SQ_C:  begin
            mul_a = $signed({3'b000, m_ff[2][30:0]});
            mul_b = $signed({3'b000, m_ff[2][30:0]});
         end
         MUL_DOT_A: begin mul_a = 34'(coef[0]); mul_b = 34'(p0_ff[0]); end
         MUL_DOT_B: begin mul_a = 34'(coef[1]); mul_b = 34'(p0_ff[1]); end
         MUL_DOT_C: begin mul_a = 34'(coef[2]); mul_b = 34'(p0_ff[2]); end
         default:   begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      pend_ff <= cmd.mul_op;
   end

   // normalization shift and the scaled 0.1 term
   assign m_or           = m_ff[0] | m_ff[1] | m_ff[2];
   assign sts.norm_done  = (m_or[65:31] == '0);
   assign k_sh           = {s_ff, 1'b0};
   assign k_val          = k_sh[6] ? 64'd0 : (TENTH_Q64 >> k_sh[5:0]);

   // square root, one result bit a step
   assign rem_sh  = {rem_ff[32:0], sum_ff[63:62]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign divisor = (root_ff == '0) ? 32'd1 : root_ff;

   always_ff @(posedge clock) begin
      // products land from the product register in the cycle after the operation issues
      unique case (pend_ff)
         MUL_X0:    n_ff[0] <= prod_ff[66:0];
         MUL_X1:    n_ff[0] <= n_ff[0] - prod_ff[66:0];
         MUL_Y0:    n_ff[1] <= prod_ff[66:0];
         MUL_Y1:    n_ff[1] <= n_ff[1] - prod_ff[66:0];
         MUL_Z0:    n_ff[2] <= prod_ff[66:0];
         MUL_Z1:    n_ff[2] <= n_ff[2] - prod_ff[66:0];
         MUL_DOT_A: dot_ff  <= prod_ff[65:0];
         MUL_DOT_B,
         MUL_DOT_C: dot_ff  <= dot_ff + prod_ff[65:0];
         default:   ;
      endcase

      if (cmd.sum_init) begin
         sum_ff <= k_val;
      end else if (pend_ff == MUL_SQ_A || pend_ff == MUL_SQ_B || pend_ff == MUL_SQ_C) begin
         sum_ff <= sum_ff + prod_ff[63:0];
      end else if (cmd.sqrt_step) begin
         sum_ff <= {sum_ff[61:0], 2'b00};
      end

      if (cmd.abs_en) begin
         s_ff <= '0;
      end else if (cmd.norm_step) begin
         s_ff <= s_ff + 1'b1;
      end

      for (int k = 0; k < 3; k++) begin
         if (cmd.abs_en) begin
            neg_ff[k] <= n_ff[k][66];
            m_ff[k]   <= n_ff[k][66] ? 66'(-n_ff[k]) : 66'(n_ff[k]);
         end else if (cmd.norm_step) begin
            m_ff[k] <= m_ff[k] >> 1;
         end
      end

      if (cmd.sqrt_init) begin
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end

      // three restoring dividers, one quotient bit a step
      if (cmd.div_init) begin
         den_ff <= {divisor, 30'd0};
      end else if (cmd.div_step) begin
         den_ff <= den_ff >> 1;
      end
      for (int k = 0; k < 3; k++) begin
         if (cmd.div_init) begin
            dr_ff[k] <= {m_ff[k][30:0], 30'd0};
            q_ff[k]  <= '0;
         end else if (cmd.div_step) begin
            if ({1'b0, dr_ff[k]} >= den_ff) begin
               dr_ff[k] <= dr_ff[k] - den_ff[60:0];
               q_ff[k]  <= {q_ff[k][29:0], 1'b1};
            end else begin
               q_ff[k]  <= {q_ff[k][29:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coef[k] = neg_ff[k] ? -$signed({1'b0, q_ff[k]}) : $signed({1'b0, q_ff[k]});
      end
   end

   // offset: truncate the magnitude toward zero, then negate
   assign dot_mag = dot_ff[65] ? 66'(-dot_ff) : 66'(dot_ff);
   assign dm      = dot_mag[65:16];
   assign d_val   = dot_ff[65] ? dm : (50'd0 - dm);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (cmd.oob) begin
            rsp_status       <= 1'b1;
            rsp_normal_a     <= '0;
            rsp_normal_b     <= '0;
            rsp_normal_c     <= '0;
            rsp_plane_offset <= '0;
         end else begin
            rsp_status       <= 1'b0;
            rsp_normal_a     <= coef[0];
            rsp_normal_b     <= coef[1];
            rsp_normal_c     <= coef[2];
            rsp_plane_offset <= d_val[47:0];
         end
      end
   end

endmodule

### hw/rtl/triangle_plane_equation_unit.sv
// ----------------------------------------------------------------------------
// triangle_plane_equation_unit
// vertex store plus plane equation of a triangle named by three corners
// ----------------------------------------------------------------------------
// Clear and append beats leave the unit idle and ready for another beat;
// an append to a full store is dropped. A face beat occupies the unit until
// its result is registered: out-of-range corners go straight to the final
// state, a full plane reads the corners, then runs the cross product, the
// normalizing shift (one bit per step), the squares, the 32-step square root,
// the 31-step dividers (three in parallel) and the offset dot product; either
// result also waits while an earlier result still waits on rsp_ready. The
// single shared 34x34 multiplier does the cross product, the squares and the
// offset dot product in turn. The result sits in an output register, so a
// new beat is taken while a finished result waits on rsp_ready.
// ----------------------------------------------------------------------------
module triangle_plane_equation_unit import tpe_pkg::*; #(
   parameter int VERTEX_DEPTH = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [11:0]        req_corner_a,
   input  logic [11:0]        req_corner_b,
   input  logic [11:0]        req_corner_c,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   output logic signed [31:0] rsp_normal_a,
   output logic signed [31:0] rsp_normal_b,
   output logic signed [31:0] rsp_normal_c,
   output logic signed [47:0] rsp_plane_offset
);

   // command and status between sequencer and datapath
   dp_cmd_type                        cmd;
   dp_status_type                     sts;
   logic [$clog2(VERTEX_DEPTH)-1:0]   wr_addr;

   // sequencer: owns the vertex count, range check and step schedule
   tpe_ctrl #(
      .VERTEX_DEPTH (VERTEX_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_corner_a (req_corner_a),
      .req_corner_b (req_corner_b),
      .req_corner_c (req_corner_c),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .sts          (sts)
   );

   // datapath: vertex memory and all arithmetic
   tpe_datapath #(
      .VERTEX_DEPTH (VERTEX_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .wr_addr          (wr_addr),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .sts              (sts),
      .rsp_status       (rsp_status),
      .rsp_normal_a     (rsp_normal_a),
      .rsp_normal_b     (rsp_normal_b),
      .rsp_normal_c     (rsp_normal_c),
      .rsp_plane_offset (rsp_plane_offset)
   );

   // a result is never written over one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // squares start only once every component fits in 31 bits
   a_norm_before_square: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_init |-> sts.norm_done)
      else $error("sum of squares started before normalization");

   // a face beat holds off intake on the following cycle
   a_face_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_FACE) |=> !req_ready)
      else $error("intake open during face work");

endmodule
